>>> hdl/bms_pkg.sv
// ----------------------------------------------------------------------------
// Bump map shader package
// Frame geometry, table sizes, operation codes and the pipeline stage record
// shared by the shader core modules.
// ----------------------------------------------------------------------------
package bms_pkg;

  // Frame geometry and light map size.
  localparam int FRAME_WIDTH        = 320;
  localparam int FRAME_PIXELS       = 64000;
  localparam int LIGHT_ADDRESS_BITS = 16;

  // Derived widths.
  localparam int COL_W       = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int POS_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int LIGHT_DEPTH = 1 << LIGHT_ADDRESS_BITS;
  localparam int COLOR_AW    = 16;
  localparam int COLOR_DEPTH = 1 << COLOR_AW;
  // Signed width that holds position plus both slopes without overflow.
  localparam int SLOPE_W     = $clog2(FRAME_WIDTH * 256 + FRAME_PIXELS) + 2;
  localparam int SUM_W       = (SLOPE_W > LIGHT_ADDRESS_BITS) ? SLOPE_W
                                                              : LIGHT_ADDRESS_BITS;

  // Operation codes; the fourth code is ignored by the core.
  typedef enum logic [1:0] {
    OP_LIGHT = 2'd0,
    OP_COLOR = 2'd1,
    OP_SHADE = 2'd2
  } op_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] table_address;
    logic [7:0]  table_value;
    logic [7:0]  height;
    logic [7:0]  texture;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] color;
    logic       end_of_frame;
  } out_item_t;

  // Item record leaving the front stage.
  typedef struct packed {
    logic             valid;
    logic [1:0]       operation;
    logic [15:0]      table_address;
    logic [7:0]       table_value;
    logic [7:0]       height;
    logic [7:0]       prev_height;
    logic [7:0]       texture;
    logic [POS_W-1:0] pos;
    logic             first_row;
    logic             last;
  } stage_t;

endpackage

>>> hdl/bms_if.sv
// ----------------------------------------------------------------------------
// Bump map shader channels
// Valid/ready channels for the input items and the shaded results.
// ----------------------------------------------------------------------------
interface bms_in_if;
  import bms_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bms_out_if;
  import bms_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/bms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
module bms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/bms_front.sv
// ----------------------------------------------------------------------------
// Bump map shader front stage
// Tracks the raster position, keeps the previous height and the row store,
// and hands each item with the height from one row above to the lookups.
// ----------------------------------------------------------------------------
module bms_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            in_valid,
  input  bms_pkg::in_item_t in_item,
  output bms_pkg::stage_t stage,
  output logic [7:0]      above_height
);
  import bms_pkg::*;

  logic             accept;
  logic             shade;
  logic             last;
  logic             first_row;
  logic [POS_W-1:0] pos;
  logic [COL_W-1:0] col;
  logic [7:0]       prev_height;

  assign accept    = in_valid && advance;
  assign shade     = (in_item.operation == OP_SHADE);
  assign last      = (pos == POS_W'(FRAME_PIXELS - 1));
  assign first_row = (32'(pos) < 32'(FRAME_WIDTH));

  // Raster position, column and previous height advance on shaded pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      col         <= '0;
      prev_height <= '0;
    end else if (accept && shade) begin
      prev_height <= in_item.height;
      if (last) begin
        pos <= '0;
        col <= '0;
      end else begin
        pos <= pos + 1'b1;
        col <= (col == COL_W'(FRAME_WIDTH - 1)) ? '0 : col + 1'b1;
      end
    end
  end

  // Stage register; it moves together with the row store read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage.valid         <= in_valid;
      stage.operation     <= in_item.operation;
      stage.table_address <= in_item.table_address;
      stage.table_value   <= in_item.table_value;
      stage.height        <= in_item.height;
      stage.prev_height   <= prev_height;
      stage.texture       <= in_item.texture;
      stage.pos           <= pos;
      stage.first_row     <= first_row;
      stage.last          <= last;
    end
  end

  // Row store: the old height of this column is read while the new one lands.
  bms_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (accept && shade),
    .waddr (col),
    .wdata (in_item.height),
    .re    (advance),
    .raddr (col),
    .rdata (above_height)
  );

  // The column always follows the position within the row.
  a_col_at_frame_start: assert property (@(posedge clk) disable iff (rst)
    (pos == '0) |-> (col == '0))
    else $error("column not zero at frame start");

  // A shaded last pixel wraps the position to the frame start.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && shade && last) |=> (pos == '0))
    else $error("position did not wrap after the last pixel");

endmodule

>>> hdl/bms_lookup.sv
// ----------------------------------------------------------------------------
// Bump map shader table lookups
// Forms the light map index from the slopes, then reads the light map and
// the color table in two stages and holds the result in the output register.
// ----------------------------------------------------------------------------
module bms_lookup (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  bms_pkg::stage_t stage,
  input  logic [7:0]      above_height,
  output logic            out_valid,
  output bms_pkg::out_item_t out_item
);
  import bms_pkg::*;

  logic signed [8:0]        dx;
  logic signed [8:0]        dy;
  logic signed [SUM_W-1:0]  dy_scaled;
  logic [SUM_W-1:0]         index_sum;
  logic [7:0]               light;
  logic [7:0]               color;

  // Second stage record.
  logic                     s2_valid;
  logic [1:0]               s2_operation;
  logic [15:0]              s2_table_address;
  logic [7:0]               s2_table_value;
  logic [7:0]               s2_texture;
  logic                     s2_first_row;
  logic                     s2_last;

  // Output register flags.
  logic                     s3_first_row;
  logic                     s3_last;

  // Light map index: position plus horizontal and scaled vertical slope.
  always_comb begin
    dx        = signed'({1'b0, stage.prev_height}) - signed'({1'b0, stage.height});
    dy        = signed'({1'b0, above_height}) - signed'({1'b0, stage.height});
    dy_scaled = SUM_W'(dy) * signed'(SUM_W'(FRAME_WIDTH));
    index_sum = SUM_W'(stage.pos) + SUM_W'(dx) + dy_scaled;
  end

  // Light map: writes and reads both happen at this stage, keeping order.
  bms_ram #(
    .WIDTH (8),
    .DEPTH (LIGHT_DEPTH)
  ) u_light_map (
    .clk   (clk),
    .we    (advance && stage.valid && (stage.operation == OP_LIGHT)),
    .waddr (LIGHT_ADDRESS_BITS'(stage.table_address)),
    .wdata (stage.table_value),
    .re    (advance),
    .raddr (index_sum[LIGHT_ADDRESS_BITS-1:0]),
    .rdata (light)
  );

  // Second stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid         <= stage.valid;
      s2_operation     <= stage.operation;
      s2_table_address <= stage.table_address;
      s2_table_value   <= stage.table_value;
      s2_texture       <= stage.texture;
      s2_first_row     <= stage.first_row;
      s2_last          <= stage.last;
    end
  end

  // Color table: row chosen by texture, column by light value.
  bms_ram #(
    .WIDTH (8),
    .DEPTH (COLOR_DEPTH)
  ) u_color_table (
    .clk   (clk),
    .we    (advance && s2_valid && (s2_operation == OP_COLOR)),
    .waddr (s2_table_address),
    .wdata (s2_table_value),
    .re    (advance),
    .raddr ({s2_texture, light}),
    .rdata (color)
  );

  // Output register; only shaded pixels produce a transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid    <= s2_valid && (s2_operation == OP_SHADE);
      s3_first_row <= s2_first_row;
      s3_last      <= s2_last;
    end
  end

  assign out_item.color        = s3_first_row ? 8'd0 : color;
  assign out_item.end_of_frame = s3_last;

  // A shaded pixel in the second stage always reaches the output register.
  a_shade_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (advance && s2_valid && (s2_operation == OP_SHADE)) |=> out_valid)
    else $error("shaded pixel lost before the output register");

  // A table write never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (advance && s2_valid && (s2_operation != OP_SHADE)) |=> !out_valid)
    else $error("table write produced a result");

  // While stalled, the held result does not change.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !advance) |=> $stable(out_item))
    else $error("held result changed during a stall");

endmodule

>>> hdl/bump_map_pixel_shader_core.sv
// ----------------------------------------------------------------------------
// Bump map pixel shader core
// Emboss bump mapping of a raster frame through a light map and color table.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock while the result register is free
// or being taken, and a shaded pixel reaches the result channel from the
// output register. Each item passes the row store read, the light map read
// and the color table read, one single-port-pair RAM per stage, and each RAM
// is touched by reads and writes of the same stage, so table loads and pixels
// may be freely interleaved and keep their order. Light map and color table
// loads give no result; every entry must be loaded before a pixel reads it.
// Pixels of the first row give color zero. When the result register is full
// and not taken, the whole pipeline holds and ready drops.
module bump_map_pixel_shader_core (
  input logic      clk,
  input logic      rst,
  bms_in_if.sink   request,
  bms_out_if.source result
);
  import bms_pkg::*;

  logic   advance;
  stage_t stage;
  logic [7:0] above_height;
  logic   out_valid;
  out_item_t out_item;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance       = !out_valid || result.ready;
  assign request.ready = advance;
  assign result.valid  = out_valid;
  assign result.payload = out_item;

  bms_front u_front (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (request.valid),
    .in_item      (request.payload),
    .stage        (stage),
    .above_height (above_height)
  );

  bms_lookup u_lookup (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .stage        (stage),
    .above_height (above_height),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  // A waiting result blocks new input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !request.ready)
    else $error("input accepted while result stalled");

endmodule
